// ===== sv/pgps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgps_pkg
// Types, codes and helpers shared by the particle step core.
// ----------------------------------------------------------------------------
package pgps_pkg;

  localparam int MAX_PARTICLES_DEF = 64;
  localparam int PIDX_W            = 6;
  localparam int CFG_IDX_W         = 1;
  localparam int CFG_DATA_W        = 24;
  localparam int TS_W              = 17;
  localparam int GRAV_W            = 24;
  localparam int ROOT_STEPS        = 32;
  localparam int DIV_STEPS         = 24;

  localparam logic [TS_W-1:0]   TS_RESET   = 17'd1049;
  localparam logic [GRAV_W-1:0] GRAV_RESET = 24'd635699;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY   = 1'd1;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_COINCIDENT = 2'd2;
  localparam logic [1:0] ST_EMPTY      = 2'd3;

  typedef struct packed {
    logic               command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic        [15:0] mass;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]        status;
    logic        [PIDX_W-1:0] particle_index;
    logic signed [31:0]       out_pos_x;
    logic signed [31:0]       out_pos_y;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic        [15:0] m;
  } rec_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  // a +/- m, saturated to signed 32 bits
  function automatic logic signed [31:0] add_mag(input logic signed [31:0] a,
                                                 input logic [32:0] m,
                                                 input logic neg);
    logic signed [34:0] mv;
    logic signed [34:0] s;
    mv = $signed({2'b00, m});
    s  = $signed({{3{a[31]}}, a}) + (neg ? -mv : mv);
    if (s > $signed(35'h0_7FFF_FFFF)) begin
      add_mag = 32'sh7FFF_FFFF;
    end else if (s < $signed(35'h7_8000_0000)) begin
      add_mag = 32'sh8000_0000;
    end else begin
      add_mag = s[31:0];
    end
  endfunction

endpackage

// ===== sv/pgps_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgps_mem
// Particle record store, one write and one registered read port.
// ----------------------------------------------------------------------------
module pgps_mem #(
  parameter int DEPTH = pgps_pkg::MAX_PARTICLES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  pgps_pkg::rec_t  wdata,
  input  logic [AW-1:0]   raddr,
  output pgps_pkg::rec_t  rdata
);
  import pgps_pkg::*;

  rec_t mem [DEPTH];
  rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/pgps_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgps_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module pgps_mul (
  input  logic        clk,
  input  logic        go,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);
  import pgps_pkg::*;

  logic [63:0] p_r;

  always_ff @(posedge clk) begin
    if (go) begin
      p_r <= a * b;
    end
  end

  assign p = p_r;

endmodule

// ===== sv/pgps_root.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgps_root
// Integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module pgps_root (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] n,
  output logic        done,
  output logic [31:0] root
);
  import pgps_pkg::*;

  logic        act_r;
  logic        done_r;
  logic [4:0]  step_r;
  logic [63:0] nsh_r;
  logic [34:0] rem_r;
  logic [31:0] root_r;
  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        ge;

  assign rem_sh = {rem_r[32:0], nsh_r[63:62]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        act_r  <= 1'b1;
        step_r <= '0;
      end else if (act_r) begin
        step_r <= step_r + 5'd1;
        if (step_r == 5'(ROOT_STEPS - 1)) begin
          act_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      nsh_r  <= n;
      rem_r  <= '0;
      root_r <= '0;
    end else if (act_r) begin
      nsh_r  <= {nsh_r[61:0], 2'b00};
      rem_r  <= ge ? rem_sh - trial : rem_sh;
      root_r <= {root_r[30:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== sv/pgps_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgps_div
// Restoring divider, one quotient bit per cycle, 24-bit quotient.
// Dividend upper part must be below the divisor.
// ----------------------------------------------------------------------------
module pgps_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [54:0] n,
  input  logic [31:0] d,
  output logic        done,
  output logic [23:0] q
);
  import pgps_pkg::*;

  logic        act_r;
  logic        done_r;
  logic [4:0]  step_r;
  logic [31:0] rem_r;
  logic [23:0] lo_r;
  logic [31:0] d_r;
  logic [23:0] q_r;
  logic [32:0] t;
  logic        ge;

  assign t  = {rem_r, lo_r[23]};
  assign ge = t >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        act_r  <= 1'b1;
        step_r <= '0;
      end else if (act_r) begin
        step_r <= step_r + 5'd1;
        if (step_r == 5'(DIV_STEPS - 1)) begin
          act_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= {1'b0, n[54:24]};
      lo_r  <= n[23:0];
      d_r   <= d;
      q_r   <= '0;
    end else if (act_r) begin
      rem_r <= ge ? 32'(t - {1'b0, d_r}) : t[31:0];
      lo_r  <= {lo_r[22:0], 1'b0};
      q_r   <= {q_r[22:0], ge};
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ===== sv/pairwise_gravity_particle_step_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_gravity_particle_step_core
// Direct-sum 2D gravity with an Euler step over a particle store.
//
// An item is taken when start is high and busy is low. Add items (command 0)
// store one particle when the store has room and give one result the next
// cycle; busy stays low. Tick items (command 1) raise busy and walk every
// pair i<j: each pair runs the square root and two divisions plus four double
// multiplies on the shared multiplier. Then each particle moves and its
// position goes out on out_valid, the final one with last set. Empty ticks
// and aborted ticks give a single status result. Results are strobed for
// one cycle on out_valid; the receiver cannot stall. Reset clears the
// particle count and loads the default time step and gravity; configuration
// is written at any edge with cfg_we high. The user must write it only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module pairwise_gravity_particle_step_core #(
  parameter int MAX_PARTICLES = pgps_pkg::MAX_PARTICLES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  pgps_pkg::in_item_t               in_item,
  output logic                             out_valid,
  output pgps_pkg::out_item_t              out_item,
  input  logic                             cfg_we,
  input  logic [pgps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pgps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import pgps_pkg::*;

  localparam int IW = $clog2(MAX_PARTICLES);
  localparam int CW = $clog2(MAX_PARTICLES + 1);

  typedef enum logic [19:0] {
    S_IDLE = 20'h00001,
    S_LDI  = 20'h00002,
    S_LDJ  = 20'h00004,
    S_SCL  = 20'h00008,
    S_SQX  = 20'h00010,
    S_SQY  = 20'h00020,
    S_SUM  = 20'h00040,
    S_ROOT = 20'h00080,
    S_DIVX = 20'h00100,
    S_DIVY = 20'h00200,
    S_VM1  = 20'h00400,
    S_VM2  = 20'h00800,
    S_VM3  = 20'h01000,
    S_WRJ  = 20'h02000,
    S_WRI  = 20'h04000,
    S_MVR  = 20'h08000,
    S_MVL  = 20'h10000,
    S_MX   = 20'h20000,
    S_MY   = 20'h40000,
    S_MW   = 20'h80000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      i_r, i_nxt;
  logic [CW-1:0]      j_r, j_nxt;
  logic [1:0]         k_r, k_nxt;
  logic [TS_W-1:0]    ts_r, ts_nxt;
  logic [GRAV_W-1:0]  grav_r, grav_nxt;
  rec_t               pi_r, pi_nxt;
  rec_t               pj_r, pj_nxt;
  logic signed [32:0] dx_r, dx_nxt;
  logic signed [32:0] dy_r, dy_nxt;
  logic [30:0]        bx_r, bx_nxt;
  logic [30:0]        by_r, by_nxt;
  logic               sx_r, sx_nxt;
  logic               sy_r, sy_nxt;
  logic [61:0]        sqx_r, sqx_nxt;
  logic [31:0]        dist_r, dist_nxt;
  logic [23:0]        qx_r, qx_nxt;
  logic [23:0]        qy_r, qy_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  rec_t               mem_wdata;
  logic [IW-1:0]      mem_raddr;
  rec_t               mem_rdata;

  logic               mul_go;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;

  logic               root_go;
  logic [63:0]        root_n;
  logic               root_done;
  logic [31:0]        root_q;

  logic               div_go;
  logic [54:0]        div_n;
  logic [31:0]        div_d;
  logic               div_done;
  logic [23:0]        div_q;

  logic [32:0]        ax, ay;
  logic               big;
  logic [31:0]        dsel;
  logic               vneg;
  logic signed [31:0] py_new;

  pgps_mem #(.DEPTH(MAX_PARTICLES), .AW(IW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pgps_mul u_mul (
    .clk (clk),
    .go  (mul_go),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  pgps_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (root_go),
    .n     (root_n),
    .done  (root_done),
    .root  (root_q)
  );

  pgps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .n     (div_n),
    .d     (div_d),
    .done  (div_done),
    .q     (div_q)
  );

  assign ax   = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
  assign ay   = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
  assign big  = (ax[32:31] != 2'b00) || (ay[32:31] != 2'b00);
  assign dsel = (root_q == 32'd0) ? 32'd1 : root_q;
  assign vneg = (k_r[0] ? sy_r : sx_r) ^ k_r[1];
  assign py_new = add_mag(pj_r.py, {1'b0, mul_p[47:16]}, pj_r.vy[31]);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    ts_nxt        = ts_r;
    grav_nxt      = grav_r;
    pi_nxt        = pi_r;
    pj_nxt        = pj_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    sqx_nxt       = sqx_r;
    dist_nxt      = dist_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = i_r[IW-1:0];
    mem_wdata     = pi_r;
    mem_raddr     = j_r[IW-1:0];
    mul_go        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    root_go       = 1'b0;
    root_n        = {1'b0, 1'b0, sqx_r} + {2'b00, mul_p[61:0]};
    div_go        = 1'b0;
    div_n         = mul_p[54:0];
    div_d         = dist_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_TIME_STEP: ts_nxt   = cfg_wdata[TS_W-1:0];
        CFG_GRAVITY:   grav_nxt = cfg_wdata[GRAV_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_valid_nxt          = 1'b1;
          out_nxt.status         = ST_OK;
          out_nxt.particle_index = '0;
          out_nxt.out_pos_x      = '0;
          out_nxt.out_pos_y      = '0;
          out_nxt.last           = 1'b1;
          if (in_item.command == CMD_ADD) begin
            if (cnt_r == CW'(MAX_PARTICLES)) begin
              out_nxt.status = ST_FULL;
            end else begin
              mem_we       = 1'b1;
              mem_waddr    = cnt_r[IW-1:0];
              mem_wdata.px = in_item.pos_x;
              mem_wdata.py = in_item.pos_y;
              mem_wdata.vx = in_item.vel_x;
              mem_wdata.vy = in_item.vel_y;
              mem_wdata.m  = in_item.mass;
              cnt_nxt      = cnt_r + CW'(1);
            end
          end else if (cnt_r == '0) begin
            out_nxt.status = ST_EMPTY;
          end else begin
            out_valid_nxt = 1'b0;
            i_nxt         = '0;
            mem_raddr     = '0;
            state_nxt     = (cnt_r == CW'(1)) ? S_MVR : S_LDI;
          end
        end
      end
      S_LDI: begin
        pi_nxt    = mem_rdata;
        j_nxt     = i_r + CW'(1);
        mem_raddr = IW'(i_r + CW'(1));
        state_nxt = S_LDJ;
      end
      S_LDJ: begin
        pj_nxt    = mem_rdata;
        dx_nxt    = $signed({mem_rdata.px[31], mem_rdata.px})
                  - $signed({pi_r.px[31], pi_r.px});
        dy_nxt    = $signed({mem_rdata.py[31], mem_rdata.py})
                  - $signed({pi_r.py[31], pi_r.py});
        state_nxt = S_SCL;
      end
      S_SCL: begin
        if ((dx_r == '0) && (dy_r == '0)) begin
          mem_we                 = 1'b1;
          out_valid_nxt          = 1'b1;
          out_nxt.status         = ST_COINCIDENT;
          out_nxt.particle_index = '0;
          out_nxt.out_pos_x      = '0;
          out_nxt.out_pos_y      = '0;
          out_nxt.last           = 1'b1;
          state_nxt              = S_IDLE;
        end else begin
          bx_nxt    = big ? ax[31:1] : ax[30:0];
          by_nxt    = big ? ay[31:1] : ay[30:0];
          sx_nxt    = dx_r[32];
          sy_nxt    = dy_r[32];
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        mul_go    = 1'b1;
        mul_a     = {1'b0, bx_r};
        mul_b     = {1'b0, bx_r};
        state_nxt = S_SQY;
      end
      S_SQY: begin
        sqx_nxt   = mul_p[61:0];
        mul_go    = 1'b1;
        mul_a     = {1'b0, by_r};
        mul_b     = {1'b0, by_r};
        state_nxt = S_SUM;
      end
      S_SUM: begin
        root_go   = 1'b1;
        mul_go    = 1'b1;
        mul_a     = {1'b0, bx_r};
        mul_b     = 32'(grav_r);
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (root_done) begin
          dist_nxt  = dsel;
          div_go    = 1'b1;
          div_d     = dsel;
          mul_go    = 1'b1;
          mul_a     = {1'b0, by_r};
          mul_b     = 32'(grav_r);
          state_nxt = S_DIVX;
        end
      end
      S_DIVX: begin
        if (div_done) begin
          qx_nxt    = div_q;
          div_go    = 1'b1;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          qy_nxt    = div_q;
          k_nxt     = '0;
          state_nxt = S_VM1;
        end
      end
      S_VM1: begin
        mul_go    = 1'b1;
        mul_a     = 32'(k_r[0] ? qy_r : qx_r);
        mul_b     = 32'(k_r[1] ? pi_r.m : pj_r.m);
        state_nxt = S_VM2;
      end
      S_VM2: begin
        mul_go    = 1'b1;
        mul_a     = mul_p[39:8];
        mul_b     = 32'(ts_r);
        state_nxt = S_VM3;
      end
      S_VM3: begin
        case (k_r)
          2'd0:    pi_nxt.vx = add_mag(pi_r.vx, mul_p[48:16], vneg);
          2'd1:    pi_nxt.vy = add_mag(pi_r.vy, mul_p[48:16], vneg);
          2'd2:    pj_nxt.vx = add_mag(pj_r.vx, mul_p[48:16], vneg);
          default: pj_nxt.vy = add_mag(pj_r.vy, mul_p[48:16], vneg);
        endcase
        k_nxt     = k_r + 2'd1;
        state_nxt = (k_r == 2'd3) ? S_WRJ : S_VM1;
      end
      S_WRJ: begin
        mem_we    = 1'b1;
        mem_waddr = j_r[IW-1:0];
        mem_wdata = pj_r;
        if (j_r + CW'(1) == cnt_r) begin
          state_nxt = S_WRI;
        end else begin
          j_nxt     = j_r + CW'(1);
          mem_raddr = IW'(j_r + CW'(1));
          state_nxt = S_LDJ;
        end
      end
      S_WRI: begin
        mem_we = 1'b1;
        if (i_r + CW'(2) < cnt_r) begin
          i_nxt     = i_r + CW'(1);
          mem_raddr = IW'(i_r + CW'(1));
          state_nxt = S_LDI;
        end else begin
          i_nxt     = '0;
          state_nxt = S_MVR;
        end
      end
      S_MVR: begin
        mem_raddr = i_r[IW-1:0];
        state_nxt = S_MVL;
      end
      S_MVL: begin
        pj_nxt    = mem_rdata;
        state_nxt = S_MX;
      end
      S_MX: begin
        mul_go    = 1'b1;
        mul_a     = mag32(pj_r.vx);
        mul_b     = 32'(ts_r);
        state_nxt = S_MY;
      end
      S_MY: begin
        pj_nxt.px = add_mag(pj_r.px, {1'b0, mul_p[47:16]}, pj_r.vx[31]);
        mul_go    = 1'b1;
        mul_a     = mag32(pj_r.vy);
        mul_b     = 32'(ts_r);
        state_nxt = S_MW;
      end
      S_MW: begin
        mem_we                 = 1'b1;
        mem_wdata              = pj_r;
        mem_wdata.py           = py_new;
        out_valid_nxt          = 1'b1;
        out_nxt.status         = ST_OK;
        out_nxt.particle_index = PIDX_W'(i_r);
        out_nxt.out_pos_x      = pj_r.px;
        out_nxt.out_pos_y      = py_new;
        out_nxt.last           = (i_r + CW'(1) == cnt_r);
        if (i_r + CW'(1) == cnt_r) begin
          i_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          i_nxt     = i_r + CW'(1);
          mem_raddr = IW'(i_r + CW'(1));
          state_nxt = S_MVL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      ts_r        <= TS_RESET;
      grav_r      <= GRAV_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      ts_r        <= ts_nxt;
      grav_r      <= grav_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pi_r   <= pi_nxt;
    pj_r   <= pj_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    bx_r   <= bx_nxt;
    by_r   <= by_nxt;
    sx_r   <= sx_nxt;
    sy_r   <= sy_nxt;
    sqx_r  <= sqx_nxt;
    dist_r <= dist_nxt;
    qx_r   <= qx_nxt;
    qy_r   <= qy_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_end_of_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && out_item.last)
    else $error("tick ended without a final result");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_PARTICLES))
    else $error("particle count beyond store depth");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != ST_OK) |-> out_item.last)
    else $error("status result not marked last");

  a_root_wait: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> state_r == S_ROOT)
    else $error("square root finished while not awaited");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVX) || (state_r == S_DIVY))
    else $error("division finished while not awaited");

endmodule

// ===== tb/tb_pairwise_gravity_particle_step_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pairwise_gravity_particle_step_core
// Self-checking bench for the 2D gravity particle step core.
//
// Adds and ticks go in on the start/busy handshake. A scoreboard class keeps
// its own copy of the particle store and of the time step and gravity
// registers, works out every position report in Q16.16 for each accepted
// item, and compares the strobed results in order. Directed items cover the
// empty tick, field extremes, a single particle, register extremes and a zero
// time step; random items follow on a small store. The run ends by filling
// the store, forcing a coincident pair and trying an add on a full store.
// ----------------------------------------------------------------------------
module tb_pairwise_gravity_particle_step_core;
  import pgps_pkg::*;

  localparam int NPART = MAX_PARTICLES_DEF;

  class grav_scoreboard;
    out_item_t   expq[$];
    int          errors;
    logic [16:0] tstep;
    logic [23:0] grav;
    longint      px[NPART];
    longint      py[NPART];
    longint      vx[NPART];
    longint      vy[NPART];
    longint      mss[NPART];
    int          cnt;

    function new();
      errors = 0;
      tstep  = TS_RESET;
      grav   = GRAV_RESET;
      cnt    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
      if (idx == CFG_TIME_STEP) tstep = val[16:0];
      else grav = val;
    endfunction

    function int pending();
      return expq.size();
    endfunction

    function void report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint root(longint n);
      longint res;
      longint b;
      res = 0;
      b = 64'sd1 << 62;
      while (b > n) b = b >>> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >>> 1) + b;
        end else begin
          res = res >>> 1;
        end
        b = b >>> 2;
      end
      return res;
    endfunction

    function longint pull(longint qm, bit neg, longint m);
      longint a;
      a = ((qm * m) >>> 8);
      a = (a * longint'(tstep)) >>> 16;
      return neg ? -a : a;
    endfunction

    function void push(logic [1:0] st, int idx, longint x, longint y, bit lst);
      out_item_t r;
      r.status         = st;
      r.particle_index = idx[PIDX_W-1:0];
      r.out_pos_x      = x[31:0];
      r.out_pos_y      = y[31:0];
      r.last           = lst;
      expq.push_back(r);
    endfunction

    function void note_item(in_item_t it);
      longint dx, dy, ax, ay, dlen, qx, qy, d;
      if (it.command == CMD_ADD) begin
        if (cnt >= NPART) begin
          push(ST_FULL, 0, 0, 0, 1);
          return;
        end
        px[cnt]  = longint'(it.pos_x);
        py[cnt]  = longint'(it.pos_y);
        vx[cnt]  = longint'(it.vel_x);
        vy[cnt]  = longint'(it.vel_y);
        mss[cnt] = longint'({48'd0, it.mass});
        cnt++;
        push(ST_OK, 0, 0, 0, 1);
        return;
      end
      if (cnt == 0) begin
        push(ST_EMPTY, 0, 0, 0, 1);
        return;
      end
      for (int i = 0; i + 1 < cnt; i++) begin
        for (int j = i + 1; j < cnt; j++) begin
          dx = px[j] - px[i];
          dy = py[j] - py[i];
          ax = dx < 0 ? -dx : dx;
          ay = dy < 0 ? -dy : dy;
          if (ax == 0 && ay == 0) begin
            push(ST_COINCIDENT, 0, 0, 0, 1);
            return;
          end
          if (ax >= 64'sh8000_0000 || ay >= 64'sh8000_0000) begin
            ax = ax >>> 1;
            ay = ay >>> 1;
          end
          dlen = root(ax * ax + ay * ay);
          if (dlen == 0) dlen = 1;
          qx = (ax * longint'(grav)) / dlen;
          qy = (ay * longint'(grav)) / dlen;
          vx[i] = sat32(vx[i] + pull(qx, dx < 0, mss[j]));
          vy[i] = sat32(vy[i] + pull(qy, dy < 0, mss[j]));
          vx[j] = sat32(vx[j] - pull(qx, dx < 0, mss[i]));
          vy[j] = sat32(vy[j] - pull(qy, dy < 0, mss[i]));
        end
      end
      for (int i = 0; i < cnt; i++) begin
        d = ((vx[i] < 0 ? -vx[i] : vx[i]) * longint'(tstep)) >>> 16;
        px[i] = sat32(px[i] + (vx[i] < 0 ? -d : d));
        d = ((vy[i] < 0 ? -vy[i] : vy[i]) * longint'(tstep)) >>> 16;
        py[i] = sat32(py[i] + (vy[i] < 0 ? -d : d));
        push(ST_OK, i, px[i], py[i], i + 1 == cnt);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expq.size() == 0) begin
        report_mismatch("unexpected result status", got.status, -1);
        return;
      end
      want = expq.pop_front();
      if (got.status != want.status)
        report_mismatch("status", got.status, want.status);
      if (got.particle_index != want.particle_index)
        report_mismatch("particle_index", got.particle_index, want.particle_index);
      if (got.out_pos_x != want.out_pos_x)
        report_mismatch("out_pos_x", got.out_pos_x, want.out_pos_x);
      if (got.out_pos_y != want.out_pos_y)
        report_mismatch("out_pos_y", got.out_pos_y, want.out_pos_y);
      if (got.last != want.last)
        report_mismatch("last", got.last, want.last);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_item = '0;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  grav_scoreboard sb = new();
  bit             quiet = 1'b0;

  pairwise_gravity_particle_step_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  initial begin
    #8000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_item(in_item_t it);
    int gap;
    gap = 0;
    if (!quiet) while ($urandom_range(99) < 30) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we    <= 1'b0;
  endtask

  function automatic in_item_t tick_item();
    in_item_t it;
    it.command = CMD_TICK;
    it.pos_x   = $urandom;
    it.pos_y   = $urandom;
    it.vel_x   = $urandom;
    it.vel_y   = $urandom;
    it.mass    = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t add_item(int px, int py, int vx, int vy, int m);
    in_item_t it;
    it.command = CMD_ADD;
    it.pos_x   = px;
    it.pos_y   = py;
    it.vel_x   = vx;
    it.vel_y   = vy;
    it.mass    = m[15:0];
    return it;
  endfunction

  function automatic int small_vel();
    return int'($urandom_range(0, 2097151)) - 1048576;
  endfunction

  function automatic in_item_t rand_add();
    return add_item($urandom, $urandom, small_vel(), small_vel(), $urandom_range(0, 65535));
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(tick_item());
    send_item(add_item(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                       65535));
    send_item(tick_item());
    send_item(add_item(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0));
    send_item(tick_item());
    send_item(rand_add());
    send_item(tick_item());
    write_cfg(CFG_TIME_STEP, 24'd65536);
    write_cfg(CFG_GRAVITY, 24'd0);
    send_item(tick_item());
    send_item(tick_item());
    write_cfg(CFG_TIME_STEP, 24'd1);
    write_cfg(CFG_GRAVITY, 24'hFF_FFFF);
    send_item(tick_item());
    write_cfg(CFG_TIME_STEP, 24'd0);
    send_item(tick_item());
    write_cfg(CFG_TIME_STEP, 24'(TS_RESET));
    write_cfg(CFG_GRAVITY, 24'(GRAV_RESET));

    for (int k = 0; k < 32; k++) begin
      quiet = (k >= 8 && k < 24);
      if (k == 16) drain_results();
      if (k == 26) begin
        write_cfg(CFG_TIME_STEP, 24'($urandom_range(1, 65536)));
        write_cfg(CFG_GRAVITY, 24'($urandom_range(0, 1048575)));
      end
      if (sb.cnt < 10 && $urandom_range(99) < 40) send_item(rand_add());
      else send_item(tick_item());
    end
    quiet = 1'b0;

    write_cfg(CFG_TIME_STEP, 24'(TS_RESET));
    write_cfg(CFG_GRAVITY, 24'(GRAV_RESET));
    while (sb.cnt < NPART - 1) send_item(rand_add());
    send_item(tick_item());
    // copy of particle 0 makes a coincident pair
    send_item(add_item(int'(sb.px[0]), int'(sb.py[0]), small_vel(), small_vel(),
                       $urandom_range(0, 65535)));
    send_item(tick_item());
    send_item(rand_add());
    send_item(tick_item());

    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch("results never seen", 0, sb.pending());
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
